// ===== sv/bbd_pkg.sv =====
// Shared types and constants for the Bayer bilinear demosaic.
package bbd_pkg;

    localparam int BBD_MAX_WIDTH = 4096;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int RAW_W     = 10;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);

    localparam int FRAME_WIDTH_RESET  = 1920;
    localparam int FRAME_HEIGHT_RESET = 1080;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // One new window column plus the position flags of the pixel that brought it.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic             emit;      // row >= 1 and column >= 1
        logic             left_rep;  // column 1: left neighbor replicated
        logic             col_last;
        logic             row_last;
        logic             col_odd;
        logic             row_odd;
    } bbd_col_t;

endpackage

// ===== sv/bbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bbd_line_buf.sv =====
// Frame position counters, frame size registers and the two-row line store.
module bbd_line_buf
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = BBD_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic [RAW_W-1:0]     raw_pixel,
    output logic                 col_valid,
    output bbd_col_t             col_data,
    input  logic                 col_take
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RESET_W = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

    logic [CW-1:0]    col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic             s1_emit_reg, s1_left_reg, s1_clast_reg, s1_rlast_reg;
    logic             s1_rtop_reg, s1_codd_reg, s1_rodd_reg;

    logic                 accept;
    logic                 s1_adv;
    logic                 cfg_hit;
    logic [2*PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]     prev_px, older_px;
    logic [CW-1:0]        cfg_col_last;
    logic [ROW_W-1:0]     cfg_row_last;

    assign s1_adv    = s1_valid_reg && col_take;
    assign pix_stall = s1_valid_reg && !col_take;
    assign accept    = pix_valid && !pix_stall;

    // Entry holds {row two back, row one back} at each column
    assign older_px = ram_rdata[2*PIX_W-1:PIX_W];
    assign prev_px  = ram_rdata[PIX_W-1:0];

    bbd_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata ({prev_px, s1_px_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Clamp of configured sizes, stored as last index
    always_comb
    begin
        if (cfg_data < CFG_W'(2))
            cfg_col_last = CW'(1);
        else if (int'(cfg_data) >= MAX_WIDTH)
            cfg_col_last = CW'(MAX_WIDTH - 1);
        else
            cfg_col_last = CW'(cfg_data - CFG_W'(1));

        if (cfg_data < CFG_W'(2))
            cfg_row_last = ROW_W'(1);
        else if (int'(cfg_data) >= HEIGHT_LIMIT)
            cfg_row_last = ROW_W'(HEIGHT_LIMIT - 1);
        else
            cfg_row_last = ROW_W'(cfg_data - CFG_W'(1));
    end

    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        cfg_hit       = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    col_last_next = cfg_col_last;
                    cfg_hit       = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    row_last_next = cfg_row_last;
                    cfg_hit       = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CW'(RESET_W - 1);
            row_last_reg <= ROW_W'(FRAME_HEIGHT_RESET - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= raw_pixel[RAW_W-1:RAW_W-PIX_W];
            s1_addr_reg  <= col_reg;
            s1_emit_reg  <= (row_reg != '0) && (col_reg != '0);
            s1_left_reg  <= (col_reg == CW'(1));
            s1_clast_reg <= (col_reg == col_last_reg);
            s1_rlast_reg <= (row_reg == row_last_reg);
            s1_rtop_reg  <= (row_reg <= ROW_W'(1));
            s1_codd_reg  <= col_reg[0];
            s1_rodd_reg  <= row_reg[0];
        end
    end

    assign col_valid         = s1_valid_reg;
    assign col_data.top      = s1_rtop_reg ? prev_px : older_px;
    assign col_data.mid      = prev_px;
    assign col_data.bot      = s1_px_reg;
    assign col_data.emit     = s1_emit_reg;
    assign col_data.left_rep = s1_left_reg;
    assign col_data.col_last = s1_clast_reg;
    assign col_data.row_last = s1_rlast_reg;
    assign col_data.col_odd  = s1_codd_reg;
    assign col_data.row_odd  = s1_rodd_reg;

    // Read and write-back in the same cycle never touch the same column
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && accept) |-> (s1_addr_reg != col_reg))
        else $error("line store read and write collide");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= col_last_reg)
        else $error("column counter past row end");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= row_last_reg)
        else $error("row counter past frame end");

endmodule

// ===== sv/bbd_interp.sv =====
// 3x3 window, result sequencer and bilinear color interpolation with output register.
module bbd_interp
    import bbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             col_valid,
    input  bbd_col_t         col_data,
    output logic             col_take,
    output logic             rgb_valid,
    input  logic             rgb_stall,
    output logic [PIX_W-1:0] blue,
    output logic [PIX_W-1:0] green,
    output logic [PIX_W-1:0] red,
    output logic             last_in_run,
    output logic             frame_end
);

    // Window entry r*3+c: r=0 top row, c=2 newest column
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];

    // Pending results: bit0 above-left, bit1 above-right flush,
    // bit2 last-row left, bit3 last-row right flush
    logic [3:0] pend_reg, pend_next;
    logic       s2_left_reg, s2_codd_reg, s2_rodd_reg;

    logic             rgb_valid_reg, rgb_valid_next;
    logic [PIX_W-1:0] blue_reg, green_reg, red_reg;
    logic             last_reg, fend_reg;

    logic       out_free, s2_move, load;
    logic [3:0] low_bit, pend_after;
    logic       low_rows, right_cols;
    logic       y_odd, x_odd;
    logic [PIX_W-1:0] nb [9];
    logic [PIX_W-1:0] row_pix [3][3];
    logic [PIX_W:0]   horiz, vert;
    logic [PIX_W+1:0] diag, cross_sum;
    logic [PIX_W-1:0] b_val, g_val, r_val;

    assign out_free   = !rgb_valid_reg || !rgb_stall;
    assign s2_move    = (pend_reg != 4'b0000) && out_free;
    assign low_bit    = pend_reg & (~pend_reg + 4'b0001);
    assign pend_after = pend_reg & ~low_bit;
    assign col_take   = (pend_reg == 4'b0000) || (s2_move && (pend_after == 4'b0000));
    assign load       = col_valid && col_take;

    assign low_rows   = !pend_reg[0] && !pend_reg[1];
    assign right_cols = !pend_reg[0] && (pend_reg[1] || !pend_reg[2]);

    // Border replication by row and column selection
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            row_pix[0][j] = low_rows ? win_reg[3 + j] : win_reg[j];
            row_pix[1][j] = low_rows ? win_reg[6 + j] : win_reg[3 + j];
            row_pix[2][j] = win_reg[6 + j];
        end
        for (int i = 0; i < 3; i++)
        begin
            nb[i*3 + 0] = (right_cols || s2_left_reg) ? row_pix[i][1] : row_pix[i][0];
            nb[i*3 + 1] = right_cols ? row_pix[i][2] : row_pix[i][1];
            nb[i*3 + 2] = row_pix[i][2];
        end
    end

    assign horiz     = {1'b0, nb[3]} + {1'b0, nb[5]};
    assign vert      = {1'b0, nb[1]} + {1'b0, nb[7]};
    assign diag      = {2'b00, nb[0]} + {2'b00, nb[2]} + {2'b00, nb[6]} + {2'b00, nb[8]};
    assign cross_sum = {1'b0, horiz} + {1'b0, vert};

    // Above row has parity opposite to the current row; same for columns
    assign y_odd = low_rows ? s2_rodd_reg : !s2_rodd_reg;
    assign x_odd = right_cols ? s2_codd_reg : !s2_codd_reg;

    always_comb
    begin
        case ({y_odd, x_odd})
            2'b00:
            begin
                b_val = nb[4];
                g_val = cross_sum[PIX_W+1:2];
                r_val = diag[PIX_W+1:2];
            end
            2'b01:
            begin
                b_val = horiz[PIX_W:1];
                g_val = nb[4];
                r_val = vert[PIX_W:1];
            end
            2'b10:
            begin
                b_val = vert[PIX_W:1];
                g_val = nb[4];
                r_val = horiz[PIX_W:1];
            end
            default:
            begin
                b_val = diag[PIX_W+1:2];
                g_val = cross_sum[PIX_W+1:2];
                r_val = nb[4];
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            win_next[i] = win_reg[i];
        pend_next = pend_reg;
        if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i*3 + 0] = win_reg[i*3 + 1];
                win_next[i*3 + 1] = win_reg[i*3 + 2];
            end
            win_next[2] = col_data.top;
            win_next[5] = col_data.mid;
            win_next[8] = col_data.bot;
            pend_next = {col_data.emit && col_data.row_last && col_data.col_last,
                         col_data.emit && col_data.row_last,
                         col_data.emit && col_data.col_last,
                         col_data.emit};
        end
        else if (s2_move)
        begin
            pend_next = pend_after;
        end
    end

    always_comb
    begin
        if (s2_move)
            rgb_valid_next = 1'b1;
        else if (out_free)
            rgb_valid_next = 1'b0;
        else
            rgb_valid_next = rgb_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            pend_reg      <= 4'b0000;
            rgb_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
            pend_reg      <= pend_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_left_reg <= col_data.left_rep;
            s2_codd_reg <= col_data.col_odd;
            s2_rodd_reg <= col_data.row_odd;
        end
        if (s2_move)
        begin
            blue_reg  <= b_val;
            green_reg <= g_val;
            red_reg   <= r_val;
            last_reg  <= (pend_after == 4'b0000);
            fend_reg  <= low_rows && right_cols;
        end
    end

    assign rgb_valid   = rgb_valid_reg;
    assign blue        = blue_reg;
    assign green       = green_reg;
    assign red         = red_reg;
    assign last_in_run = last_reg;
    assign frame_end   = fend_reg;

    // Corner flush is queued with all three other results and goes out last
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg[3] && !pend_reg[2]) |-> (pend_reg[1:0] == 2'b00))
        else $error("corner result pending ahead of earlier results");

    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid_reg && fend_reg) |-> last_reg)
        else $error("frame end not on last result of its transaction");

endmodule

// ===== sv/bayer_bilinear_demosaic.sv =====
// Top level of the BGGR bilinear demosaic: 10-bit raw in, 8-bit RGB out.
// Path: a pixel passes the line store stage, then the window, then the output register.
// Throughput: 1 pixel per cycle while rgb_stall is low; a pixel with N results (N up to 4)
// holds the input while the single interpolation datapath makes them, one per unstalled cycle.
// Reset clears counters, window and pipeline valids; size registers return to 1920 x 1080.
// Line store contents are undefined after reset and need no clearing.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = BBD_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic [RAW_W-1:0]     raw_pixel,
    output logic                 rgb_valid,
    input  logic                 rgb_stall,
    output logic [PIX_W-1:0]     blue,
    output logic [PIX_W-1:0]     green,
    output logic [PIX_W-1:0]     red,
    output logic                 last_in_run,
    output logic                 frame_end
);

    logic     col_valid;
    logic     col_take;
    bbd_col_t col_data;

    assign cfg_ready = 1'b1;

    bbd_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .raw_pixel (raw_pixel),
        .col_valid (col_valid),
        .col_data  (col_data),
        .col_take  (col_take)
    );

    bbd_interp u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .col_valid   (col_valid),
        .col_data    (col_data),
        .col_take    (col_take),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .last_in_run (last_in_run),
        .frame_end   (frame_end)
    );

endmodule
